FILE: rtl/core/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
// Used by frt_slot_store, frt_scan_unit and fragment_reassembly_tracker.
package frt_pkg;

    localparam int SLOT_COUNT     = 8;
    localparam int FRAGMENT_BYTES = 500;
    localparam int SLOT_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int NODE_W     = 8;
    localparam int SEQ_W      = 8;
    localparam int FRAG_W     = 8;
    localparam int NIB_W      = 4;
    localparam int PLEN_W     = 9;
    localparam int MASK_W     = 16;
    localparam int LEN_W      = 13;
    localparam int OUT_SLOT_W = 3;
    localparam int PROD_W     = 17;
    localparam int SUM_W      = 18;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef logic [SLOT_W-1:0] t_slot_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [SEQ_W-1:0]  seq;
        logic [MASK_W-1:0] mask;
        logic [LEN_W-1:0]  len;
    } t_slot_entry;

    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic      hit;
        t_slot_idx hit_slot;
        logic      free;
        t_slot_idx free_slot;
        logic      same;
        t_slot_idx same_slot;
    } t_scan_res;

endpackage

FILE: rtl/core/frt_slot_store.sv
// Reassembly slot table: node, sequence, received mask and length per slot.
// One read port, one write port. Depends on frt_pkg.
module frt_slot_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  frt_pkg::t_slot_idx   i_rd_addr,
    output frt_pkg::t_slot_entry o_rd_entry,
    input  logic                 i_we,
    input  frt_pkg::t_slot_idx   i_wr_addr,
    input  frt_pkg::t_slot_entry i_wr_entry
);

    frt_pkg::t_slot_entry r_slots [frt_pkg::SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < frt_pkg::SLOT_COUNT; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_we) begin
            r_slots[i_wr_addr] <= i_wr_entry;
        end
    end

    assign o_rd_entry = r_slots[i_rd_addr];

endmodule

FILE: rtl/core/frt_scan_unit.sv
// Shared compare unit: walks the slots one per cycle and keeps the first
// exact match, first free slot and first same-node slot. Depends on frt_pkg.
module frt_scan_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  frt_pkg::t_scan_ctl       i_ctl,
    input  logic [frt_pkg::NODE_W-1:0] i_node,
    input  logic [frt_pkg::SEQ_W-1:0]  i_seq,
    input  frt_pkg::t_slot_entry     i_entry,
    output frt_pkg::t_slot_idx       o_idx,
    output logic                     o_last,
    output frt_pkg::t_scan_res       o_res
);

    frt_pkg::t_slot_idx r_idx;
    frt_pkg::t_scan_res r_res;

    logic w_node_eq;
    logic w_seq_eq;
    logic w_mask_zero;

    assign w_node_eq   = (i_entry.node == i_node);
    assign w_seq_eq    = (i_entry.seq == i_seq);
    assign w_mask_zero = (i_entry.mask == '0);
    assign o_last      = (r_idx == frt_pkg::SLOT_W'(frt_pkg::SLOT_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_res <= '0;
        end else if (i_ctl.start) begin
            r_idx <= '0;
            r_res <= '0;
        end else if (i_ctl.step) begin
            if (!o_last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (!r_res.hit && w_node_eq && w_seq_eq) begin
                r_res.hit      <= 1'b1;
                r_res.hit_slot <= r_idx;
            end
            if (!r_res.free && w_mask_zero) begin
                r_res.free      <= 1'b1;
                r_res.free_slot <= r_idx;
            end
            if (!r_res.same && w_node_eq) begin
                r_res.same      <= 1'b1;
                r_res.same_slot <= r_idx;
            end
        end
    end

    assign o_idx = r_idx;
    assign o_res = r_res;

endmodule

FILE: rtl/core/fragment_reassembly_tracker.sv
// Fragment reassembly tracker top level: sequencer, slot update and output
// register. Depends on frt_pkg, frt_slot_store and frt_scan_unit.
//
// Input channel (i_in_valid / o_in_ready) carries one fragment header:
// source node, sequence byte, fragment byte (index low nibble, count high
// nibble) and payload length. Output channel (o_out_valid / i_out_ready)
// returns one result per header: chosen slot, payload byte offset, complete
// flag with stored packet length, and the node and sequence of the slot.
// A transfer happens when valid and ready are both high at a clock edge.
//
// Timing: after an input transfer the sequencer reads one slot per cycle
// through a single compare unit, then in the update state writes the
// chosen slot and loads the output register once that register is free.
// o_in_ready is high only while the sequencer is idle.
//
// Reset (i_rst_n low, synchronous) clears all slots to node 0, sequence 0,
// empty mask, length 0, and drops o_out_valid. If the receiver stalls, the
// result is held; the next header can still be scanned, and its update
// waits until the held result has been taken.
module fragment_reassembly_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [frt_pkg::NODE_W-1:0]        i_source_node,
    input  logic [frt_pkg::SEQ_W-1:0]         i_sequence_req,
    input  logic [frt_pkg::FRAG_W-1:0]        i_fragment_byte,
    input  logic [frt_pkg::PLEN_W-1:0]        i_payload_length,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [frt_pkg::OUT_SLOT_W-1:0]    o_slot,
    output logic [frt_pkg::LEN_W-1:0]         o_byte_offset,
    output logic                              o_complete,
    output logic [frt_pkg::LEN_W-1:0]         o_packet_length,
    output logic [frt_pkg::NODE_W-1:0]        o_packet_node,
    output logic [frt_pkg::SEQ_W-1:0]         o_packet_sequence
);

    frt_pkg::t_state r_state;
    frt_pkg::t_state n_state;

    // captured header
    logic [frt_pkg::NODE_W-1:0] r_node;
    logic [frt_pkg::SEQ_W-1:0]  r_seq;
    logic [frt_pkg::FRAG_W-1:0] r_frag;
    logic [frt_pkg::PLEN_W-1:0] r_plen;

    // output register
    logic                          r_out_valid;
    logic [frt_pkg::OUT_SLOT_W-1:0] r_slot;
    logic [frt_pkg::LEN_W-1:0]     r_offset;
    logic                          r_complete;
    logic [frt_pkg::LEN_W-1:0]     r_pkt_len;
    logic [frt_pkg::NODE_W-1:0]    r_pkt_node;
    logic [frt_pkg::SEQ_W-1:0]     r_pkt_seq;

    logic                 w_accept;
    logic                 w_out_busy;
    logic                 w_upd;
    frt_pkg::t_scan_ctl   w_ctl;
    frt_pkg::t_scan_res   w_res;
    frt_pkg::t_slot_idx   w_scan_idx;
    logic                 w_scan_last;
    frt_pkg::t_slot_idx   w_sel;
    logic                 w_evict;
    frt_pkg::t_slot_idx   w_rd_addr;
    frt_pkg::t_slot_entry w_rd_entry;
    frt_pkg::t_slot_entry w_wr_entry;

    logic [frt_pkg::NIB_W-1:0]  w_idx;
    logic [frt_pkg::NIB_W-1:0]  w_cnt;
    logic                       w_last_frag;
    logic [frt_pkg::PROD_W-1:0] w_prod;
    logic [frt_pkg::SUM_W-1:0]  w_sum;
    logic [frt_pkg::LEN_W-1:0]  w_offset;
    logic [frt_pkg::LEN_W-1:0]  w_new_len;
    logic [frt_pkg::MASK_W-1:0] w_base_mask;
    logic [frt_pkg::MASK_W-1:0] w_new_mask;
    logic [frt_pkg::MASK_W:0]   w_full;
    logic                       w_done;
    logic [31:0]                w_sel_wide;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            frt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = frt_pkg::S_SCAN;
                end
            end
            frt_pkg::S_SCAN: begin
                if (w_scan_last) begin
                    n_state = frt_pkg::S_UPDATE;
                end
            end
            frt_pkg::S_UPDATE: begin
                if (!w_out_busy) begin
                    n_state = frt_pkg::S_IDLE;
                end
            end
            default: n_state = frt_pkg::S_IDLE;
        endcase
    end

    assign w_out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        o_in_ready = 1'b0;
        w_ctl      = '0;
        w_upd      = 1'b0;
        case (r_state)
            frt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                w_ctl.start = 1'b1;
            end
            frt_pkg::S_SCAN: begin
                w_ctl.step = 1'b1;
            end
            frt_pkg::S_UPDATE: begin
                w_upd = !w_out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_node <= i_source_node;
            r_seq  <= i_sequence_req;
            r_frag <= i_fragment_byte;
            r_plen <= i_payload_length;
        end
    end

    // ---------------- slot scan and table ----------------
    frt_scan_unit u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_node  (r_node),
        .i_seq   (r_seq),
        .i_entry (w_rd_entry),
        .o_idx   (w_scan_idx),
        .o_last  (w_scan_last),
        .o_res   (w_res)
    );

    // match first, then free slot, then same node (evict), else slot 0 (evict)
    always_comb begin
        w_evict = 1'b0;
        if (w_res.hit) begin
            w_sel = w_res.hit_slot;
        end else if (w_res.free) begin
            w_sel = w_res.free_slot;
        end else if (w_res.same) begin
            w_sel   = w_res.same_slot;
            w_evict = 1'b1;
        end else begin
            w_sel   = '0;
            w_evict = 1'b1;
        end
    end

    assign w_rd_addr = (r_state == frt_pkg::S_SCAN) ? w_scan_idx : w_sel;

    frt_slot_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (w_rd_addr),
        .o_rd_entry (w_rd_entry),
        .i_we       (w_upd),
        .i_wr_addr  (w_sel),
        .i_wr_entry (w_wr_entry)
    );

    // ---------------- slot update ----------------
    assign w_idx = r_frag[frt_pkg::NIB_W-1:0];
    assign w_cnt = r_frag[frt_pkg::FRAG_W-1:frt_pkg::NIB_W];

    // for the last fragment (count-1)*size equals index*size
    assign w_last_frag = (w_cnt != '0) && (w_idx == w_cnt - 1'b1);
    assign w_prod      = frt_pkg::PROD_W'(w_idx)
                       * frt_pkg::PROD_W'(frt_pkg::FRAGMENT_BYTES);
    assign w_sum       = frt_pkg::SUM_W'(w_prod) + frt_pkg::SUM_W'(r_plen);
    assign w_offset    = (w_prod > frt_pkg::PROD_W'(frt_pkg::LEN_MAX))
                       ? frt_pkg::LEN_MAX : w_prod[frt_pkg::LEN_W-1:0];
    assign w_new_len   = !w_last_frag ? w_rd_entry.len
                       : (w_sum > frt_pkg::SUM_W'(frt_pkg::LEN_MAX))
                       ? frt_pkg::LEN_MAX : w_sum[frt_pkg::LEN_W-1:0];

    assign w_base_mask = w_evict ? '0 : w_rd_entry.mask;
    assign w_new_mask  = w_base_mask | (frt_pkg::MASK_W'(1) << w_idx);
    assign w_full      = ((frt_pkg::MASK_W+1)'(1) << w_cnt) - (frt_pkg::MASK_W+1)'(1);
    assign w_done      = ({1'b0, w_new_mask} == w_full);

    always_comb begin
        w_wr_entry.node = r_node;
        w_wr_entry.seq  = r_seq;
        w_wr_entry.mask = w_done ? '0 : w_new_mask;
        w_wr_entry.len  = w_new_len;
    end

    assign w_sel_wide = 32'(w_sel);

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_slot     <= w_sel_wide[frt_pkg::OUT_SLOT_W-1:0];
            r_offset   <= w_offset;
            r_complete <= w_done;
            r_pkt_len  <= w_done ? w_new_len : '0;
            r_pkt_node <= r_node;
            r_pkt_seq  <= r_seq;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_slot            = r_slot;
    assign o_byte_offset     = r_offset;
    assign o_complete        = r_complete;
    assign o_packet_length   = r_pkt_len;
    assign o_packet_node     = r_pkt_node;
    assign o_packet_sequence = r_pkt_seq;

    // ---------------- assertions ----------------
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == frt_pkg::S_SCAN)
        else $error("input transfer did not start slot scan");

    a_write_only_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd |-> (r_state == frt_pkg::S_UPDATE && !w_out_busy))
        else $error("slot table written outside update");

    a_hit_slot_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frt_pkg::S_UPDATE && w_res.hit)
            |-> (w_rd_entry.node == r_node && w_rd_entry.seq == r_seq))
        else $error("matched slot does not hold the header node and sequence");

    a_len_zero_unless_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_complete) |-> o_packet_length == '0)
        else $error("packet length reported without completion");

endmodule
